### rtl/mesi_snooping_cache_controller_defines.svh
// Assertion macros for the MESI snooping cache controller.
`ifndef MESI_SNOOPING_CACHE_CONTROLLER_DEFINES_SVH
`define MESI_SNOOPING_CACHE_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
`define MSC_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define MSC_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("%m failed");
`else
`define MSC_ASSERT_IMPL(label, clk, rst_n, prop)
`define MSC_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### rtl/msc_pkg.sv
// Package of shared constants and types for the MESI snooping cache controller.
`default_nettype none
package msc_pkg;
  localparam int LINES_DEF = 64;
  localparam int BLOCK_WORDS_DEF = 8;
  localparam int ADDR_BITS_DEF = 21;
  localparam int TAG_BITS = 12;
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_GRANT = 2'd2;
  localparam logic [1:0] OP_SNOOP = 2'd3;
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_BUSRD = 2'd1;
  localparam logic [1:0] CMD_BUSRDX = 2'd2;
  localparam logic [1:0] CMD_FLUSH = 2'd3;
  localparam logic [1:0] ST_I = 2'd0;
  localparam logic [1:0] ST_S = 2'd1;
  localparam logic [1:0] ST_E = 2'd2;
  localparam logic [1:0] ST_M = 2'd3;
  typedef enum logic [1:0] {
    PH_IDLE = 2'b01,
    PH_WORK = 2'b10
  } phase_t;
endpackage
`default_nettype wire

### rtl/msc_if.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface msc_in_if #(parameter int AW = 21);
  logic valid;
  logic ready;
  logic [1:0] operation;
  logic [AW-1:0] access_address;
  logic [31:0] write_data;
  logic [1:0] bus_command;
  logic [2:0] bus_originator;
  logic [AW-1:0] bus_address;
  logic [31:0] bus_data;
  logic bus_shared;
  modport source (output valid, operation, access_address, write_data, bus_command,
                  bus_originator, bus_address, bus_data, bus_shared, input ready);
  modport sink (input valid, operation, access_address, write_data, bus_command,
                bus_originator, bus_address, bus_data, bus_shared, output ready);
endinterface

interface msc_out_if #(parameter int AW = 21);
  logic valid;
  logic ready;
  logic hit;
  logic [31:0] read_data;
  logic core_stall;
  logic bus_request;
  logic drive_valid;
  logic [1:0] drive_command;
  logic [AW-1:0] drive_address;
  logic [31:0] drive_data;
  logic shared_assert;
  logic cancel_memory;
  logic fill_done;
  modport source (output valid, hit, read_data, core_stall, bus_request, drive_valid,
                  drive_command, drive_address, drive_data, shared_assert,
                  cancel_memory, fill_done, input ready);
  modport sink (input valid, hit, read_data, core_stall, bus_request, drive_valid,
                drive_command, drive_address, drive_data, shared_assert,
                cancel_memory, fill_done, output ready);
endinterface
`default_nettype wire

### rtl/mesi_snooping_cache_controller.sv
// The tag and data memories are read when an item is taken; the item then passes through
// the work phase, which writes back line state and words and loads the result register.
// No new item is taken before the current one has left the work phase. The next item is
// taken at the edge that transfers the result, but not while the pending store of a
// completed fill is written. Reset (rst_n low, synchronous) clears control state and runs
// a clearing pass over the line state memory, during which no item is accepted.
`default_nettype none
module mesi_snooping_cache_controller #(
  parameter int LINES = msc_pkg::LINES_DEF,
  parameter int BLOCK_WORDS = msc_pkg::BLOCK_WORDS_DEF,
  parameter int ADDR_BITS = msc_pkg::ADDR_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata,
  msc_in_if.sink          in_ch,
  msc_out_if.source       out_ch
);
  import msc_pkg::*;
  `include "mesi_snooping_cache_controller_defines.svh"

  localparam int OW = $clog2(BLOCK_WORDS);
  localparam int LW = $clog2(LINES);
  localparam int IW = LW + OW;
  localparam int CW = $clog2(BLOCK_WORDS + 1);
  localparam int LINE_BITS = TAG_BITS + 3;

  // Line metadata memory: {tag, mesi, dirty}.
  logic [LINE_BITS-1:0] meta_mem [LINES];
  logic [LINE_BITS-1:0] meta_rd;
  logic                 meta_we;
  logic [LW-1:0]        meta_wa, meta_ra;
  logic [LINE_BITS-1:0] meta_wd;

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
    meta_rd <= meta_mem[meta_ra];
  end

  logic        d_we;
  logic [IW-1:0] d_wa, d_ra;
  logic [31:0] d_wd, d_rd;
  logic [IW-1:0] d_wa_f;
  logic [31:0] d_wd_f;
  logic d_we_f;
  msc_data_ram #(.DEPTH(LINES * BLOCK_WORDS), .IW(IW)) u_data (
    .clk(clk), .we(d_we_f), .waddr(d_wa_f), .wdata(d_wd_f), .raddr(d_ra), .rdata(d_rd)
  );

  phase_t ph_r;
  logic [LW:0] clr_r;
  logic clearing;
  logic [1:0] core_id_r;
  logic [1:0] op_r, cmd_r;
  logic [ADDR_BITS-1:0] addr_r, baddr_r;
  logic [31:0] wdata_r, bdata_r;
  logic [2:0] orig_r;
  logic bshared_r;
  logic miss_r, fillrx_r, stall_r, pst_r, fsh_r, fla_r;
  logic [ADDR_BITS-1:0] pa_r, fbase_r, fptr_r;
  logic [31:0] psw_r;
  logic [CW-1:0] fcnt_r, frem_r;
  logic ov_r;
  logic hit_r, dv_r, sh_r, can_r, done_r;
  logic [1:0] dcmd_r;
  logic [ADDR_BITS-1:0] daddr_r;
  logic [31:0] rdat_r, ddat_r;
  logic ddat_sel_r, rdat_sel_r;
  logic pwr_r;
  logic [IW-1:0] pwa_r;

  // Taken if idle, not clearing, no pending store, and the output is empty or transfers.
  assign clearing = !clr_r[LW];
  assign in_ch.ready = rst_n && !clearing && ph_r == PH_IDLE && !pwr_r &&
                       (!ov_r || out_ch.ready);
  wire acc = in_ch.valid && in_ch.ready;

  function automatic logic [LW-1:0] line_of(input logic [ADDR_BITS-1:0] a);
    return a[OW +: LW];
  endfunction
  function automatic logic [TAG_BITS-1:0] tag_of(input logic [ADDR_BITS-1:0] a);
    logic [ADDR_BITS+TAG_BITS-1:0] w;
    w = {{TAG_BITS{1'b0}}, a};
    return w[OW+LW +: TAG_BITS];
  endfunction
  function automatic logic [ADDR_BITS-1:0] base_of(input logic [ADDR_BITS-1:0] a);
    return {a[ADDR_BITS-1:OW], {OW{1'b0}}};
  endfunction

  // Address selection when an item is taken: which line and word to read.
  logic [ADDR_BITS-1:0] sel_a;
  logic [OW-1:0] flush_off;
  assign flush_off = OW'(CW'(BLOCK_WORDS) - frem_r);
  always_comb begin
    case (in_ch.operation)
      OP_LOAD, OP_STORE: sel_a = in_ch.access_address;
      OP_GRANT: sel_a = fptr_r;
      default: sel_a = in_ch.bus_address;
    endcase
    meta_ra = line_of(sel_a);
    d_ra = {line_of(sel_a),
            (in_ch.operation == OP_GRANT) ? flush_off : sel_a[OW-1:0]};
  end

  // Work phase: read-modify-write of line state and words.
  logic [TAG_BITS-1:0] m_tag;
  logic [1:0] m_st;
  logic m_dirty;
  assign {m_tag, m_st, m_dirty} = meta_rd;
  wire work = ph_r == PH_WORK;

  logic [ADDR_BITS+LW+TAG_BITS-1:0] fp_w;
  always_comb begin
    meta_we = 1'b0;
    meta_wa = line_of(addr_r);
    meta_wd = meta_rd;
    d_we = 1'b0;
    d_wa = {line_of(addr_r), addr_r[OW-1:0]};
    d_wd = wdata_r;
    fp_w = '0;
    if (clearing) begin
      meta_we = 1'b1;
      meta_wa = clr_r[LW-1:0];
      meta_wd = '0;
    end else if (work) begin
      if (op_r == OP_LOAD || op_r == OP_STORE) begin
        if (!stall_r && op_r == OP_STORE && m_st != ST_I && m_tag == tag_of(addr_r)
            && m_st >= ST_E) begin
          d_we = 1'b1;
          meta_we = 1'b1;
          meta_wd = {m_tag, ST_M, 1'b1};
        end
      end else if (op_r == OP_SNOOP && cmd_r == CMD_FLUSH) begin
        if (fillrx_r && base_of(baddr_r) == fbase_r) begin
          d_we = 1'b1;
          d_wa = {line_of(baddr_r), baddr_r[OW-1:0]};
          d_wd = bdata_r;
          meta_wa = line_of(fbase_r);
          if (fcnt_r + 1'b1 >= CW'(BLOCK_WORDS)) begin
            meta_we = 1'b1;
            if (pst_r && tag_of(pa_r) == tag_of(fbase_r)) begin
              meta_wd = {tag_of(fbase_r), ST_M, 1'b1};
            end else begin
              meta_wd = {tag_of(fbase_r), fsh_r ? ST_S : ST_E, 1'b0};
            end
          end
        end
      end else if (op_r == OP_SNOOP && cmd_r != CMD_NONE) begin
        meta_wa = line_of(baddr_r);
        if (orig_r != {1'b0, core_id_r} && m_st != ST_I && m_tag == tag_of(baddr_r)) begin
          meta_we = 1'b1;
          if (cmd_r == CMD_BUSRD) begin
            meta_wd = (m_st >= ST_E) ? {m_tag, ST_S, 1'b0} : meta_rd;
          end else begin
            meta_wd = {m_tag, ST_I, 1'b0};
          end
        end
      end
      fp_w = ({{(ADDR_BITS+LW){1'b0}}, m_tag} << (LW + OW))
             | (ADDR_BITS+LW+TAG_BITS)'({line_of(baddr_r), {OW{1'b0}}});
    end
  end

  // Pending store is written into the line in the cycle after the fill completes; no item
  // is in its work phase then and the input waits, so the data port is free.
  always_comb begin
    d_we_f = d_we;
    d_wa_f = d_wa;
    d_wd_f = d_wd;
    if (pwr_r) begin
      d_we_f = 1'b1;
      d_wa_f = pwa_r;
      d_wd_f = psw_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE;
      clr_r <= '0;
      core_id_r <= 2'd0;
      miss_r <= 1'b0; fillrx_r <= 1'b0; stall_r <= 1'b0; pst_r <= 1'b0; fsh_r <= 1'b0;
      fla_r <= 1'b0; pa_r <= '0; fbase_r <= '0; fptr_r <= '0; psw_r <= '0;
      fcnt_r <= '0; frem_r <= '0; ov_r <= 1'b0; pwr_r <= 1'b0;
    end else begin
      if (pwr_r) pwr_r <= 1'b0;
      if (cfg_we) core_id_r <= cfg_wdata;
      if (clearing) clr_r <= clr_r + 1'b1;
      if (out_ch.ready && ov_r) ov_r <= 1'b0;
      if (acc) begin
        ph_r <= PH_WORK;
        op_r <= in_ch.operation; cmd_r <= in_ch.bus_command;
        addr_r <= in_ch.access_address; baddr_r <= in_ch.bus_address;
        wdata_r <= in_ch.write_data; bdata_r <= in_ch.bus_data;
        orig_r <= in_ch.bus_originator; bshared_r <= in_ch.bus_shared;
      end
      if (work) begin
        ph_r <= PH_IDLE;
        ov_r <= 1'b1;
        hit_r <= 1'b0; dv_r <= 1'b0; sh_r <= 1'b0; can_r <= 1'b0; done_r <= 1'b0;
        dcmd_r <= CMD_NONE; daddr_r <= '0; ddat_sel_r <= 1'b0; rdat_sel_r <= 1'b0;
        case (op_r)
          OP_LOAD, OP_STORE: begin
            if (!stall_r) begin
              if (m_st != ST_I && m_tag == tag_of(addr_r) &&
                  (op_r == OP_LOAD || m_st >= ST_E)) begin
                hit_r <= 1'b1;
                rdat_sel_r <= op_r == OP_LOAD;
              end else begin
                stall_r <= 1'b1; miss_r <= 1'b1; pa_r <= addr_r;
                pst_r <= op_r == OP_STORE;
                if (op_r == OP_STORE) psw_r <= wdata_r;
              end
            end
          end
          OP_GRANT: begin
            if (fla_r) begin
              dv_r <= 1'b1; dcmd_r <= CMD_FLUSH; daddr_r <= fptr_r; ddat_sel_r <= 1'b1;
              frem_r <= frem_r - 1'b1;
              fptr_r <= fptr_r + 1'b1;
              if (frem_r == CW'(1)) fla_r <= 1'b0;
            end else if (miss_r) begin
              dv_r <= 1'b1; dcmd_r <= pst_r ? CMD_BUSRDX : CMD_BUSRD; daddr_r <= pa_r;
              miss_r <= 1'b0; fillrx_r <= 1'b1; fbase_r <= base_of(pa_r);
              fcnt_r <= '0; fsh_r <= 1'b0;
            end
          end
          default: begin
            if (cmd_r == CMD_FLUSH) begin
              if (fillrx_r && base_of(baddr_r) == fbase_r) begin
                if (fcnt_r + 1'b1 >= CW'(BLOCK_WORDS)) begin
                  fillrx_r <= 1'b0; stall_r <= 1'b0; miss_r <= 1'b0; fcnt_r <= '0;
                  done_r <= 1'b1;
                  if (pst_r) begin
                    pwr_r <= 1'b1;
                    pwa_r <= {line_of(pa_r), pa_r[OW-1:0]};
                  end
                end else begin
                  fcnt_r <= fcnt_r + 1'b1;
                end
              end
            end else if (cmd_r != CMD_NONE) begin
              if (orig_r == {1'b0, core_id_r}) begin
                if (cmd_r == CMD_BUSRD) fsh_r <= bshared_r;
              end else if (m_st != ST_I && m_tag == tag_of(baddr_r)) begin
                sh_r <= 1'b1;
                if (m_dirty && (cmd_r == CMD_BUSRDX || m_st >= ST_E)) begin
                  fla_r <= 1'b1; frem_r <= CW'(BLOCK_WORDS);
                  fptr_r <= fp_w[ADDR_BITS-1:0];
                  can_r <= 1'b1;
                end
              end
            end
          end
        endcase
      end
    end
  end

  // Payload registers of the result; words come straight from the read register.
  always_ff @(posedge clk) begin
    if (work) begin
      rdat_r <= d_rd;
      ddat_r <= d_rd;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.hit = hit_r;
  assign out_ch.read_data = rdat_sel_r ? rdat_r : 32'd0;
  assign out_ch.core_stall = stall_r;
  assign out_ch.bus_request = fla_r || miss_r;
  assign out_ch.drive_valid = dv_r;
  assign out_ch.drive_command = dcmd_r;
  assign out_ch.drive_address = daddr_r;
  assign out_ch.drive_data = ddat_sel_r ? ddat_r : 32'd0;
  assign out_ch.shared_assert = sh_r;
  assign out_ch.cancel_memory = can_r;
  assign out_ch.fill_done = done_r;

  `MSC_ASSERT_NEXT(a_one_phase, clk, rst_n, work, ph_r == PH_IDLE && ov_r)
  `MSC_ASSERT_IMPL(a_no_accept_clear, clk, rst_n, clearing |-> !in_ch.ready)
  `MSC_ASSERT_IMPL(a_done_unstalls, clk, rst_n, (ov_r && done_r) |-> !stall_r)
endmodule
`default_nettype wire

### rtl/msc_data_ram.sv
// Synchronous data word memory with one write and one registered read port.
`default_nettype none
module msc_data_ram #(
  parameter int DEPTH = 512,
  parameter int IW = 9
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [IW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [IW-1:0] raddr,
  output logic      [31:0]   rdata
);
  logic [31:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### test/tb_mesi_snooping_cache_controller.sv
// Self-checking testbench for the MESI snooping cache controller.
`timescale 1ns / 100ps

module tb_mesi_snooping_cache_controller;
  import msc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PRESSURE_CYCLES = 400;
  localparam int PHASE_ITEMS = 275;
  localparam int QUIET_ITEMS = 150;

  typedef struct packed {
    logic [1:0]  operation;
    logic [20:0] access_address;
    logic [31:0] write_data;
    logic [1:0]  bus_command;
    logic [2:0]  bus_originator;
    logic [20:0] bus_address;
    logic [31:0] bus_data;
    logic        bus_shared;
  } cache_req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_data;
    logic        core_stall;
    logic        bus_request;
    logic        drive_valid;
    logic [1:0]  drive_command;
    logic [20:0] drive_address;
    logic [31:0] drive_data;
    logic        shared_assert;
    logic        cancel_memory;
    logic        fill_done;
  } cache_rsp_t;

  // Scoreboard: a private copy of the cache state that predicts each response.
  class mesi_scoreboard;
    logic [11:0] tag_mem[64];
    logic [1:0]  mesi_mem[64];
    bit          dirty_mem[64];
    logic [31:0] word_mem[512];
    bit          miss_waiting, fill_receiving, stall_flag;
    logic [20:0] pend_addr;
    bit          pend_store;
    logic [31:0] pend_word;
    int          fill_count;
    logic [20:0] fill_base;
    bit          fill_shared;
    bit          flush_active;
    int          flush_left;
    logic [20:0] flush_ptr;
    logic [1:0]  own_id;
    logic [7:0]  fill_mask;
    cache_rsp_t  rsp_queue[$];
    int          errors, load_hits, fills, flush_words, checked;

    function new();
      foreach (tag_mem[i]) begin
        tag_mem[i] = '0;
        mesi_mem[i] = ST_I;
        dirty_mem[i] = 0;
      end
      foreach (word_mem[i]) word_mem[i] = '0;
      miss_waiting = 0; fill_receiving = 0; stall_flag = 0;
      pend_addr = '0; pend_store = 0; pend_word = '0;
      fill_count = 0; fill_base = '0; fill_shared = 0;
      flush_active = 0; flush_left = 0; flush_ptr = '0;
      own_id = '0; fill_mask = '0;
      errors = 0; load_hits = 0; fills = 0; flush_words = 0; checked = 0;
    endfunction

    function void set_core(logic [1:0] v);
      own_id = v;
    endfunction

    function bit line_match(logic [20:0] a);
      return mesi_mem[a[8:3]] != ST_I && tag_mem[a[8:3]] == a[20:9];
    endfunction

    function void begin_flush(logic [5:0] l);
      flush_active = 1;
      flush_left = 8;
      flush_ptr = {tag_mem[l], l, 3'b000};
    endfunction

    // Work out the response of one accepted request and queue it.
    function void note_transfer(cache_req_t rq);
      cache_rsp_t r;
      logic [5:0] l;
      logic [2:0] off;
      r = '0;
      l = rq.access_address[8:3];
      if (rq.operation == OP_LOAD || rq.operation == OP_STORE) begin
        if (!stall_flag) begin
          if (line_match(rq.access_address) &&
              (rq.operation == OP_LOAD || mesi_mem[l] >= ST_E)) begin
            r.hit = 1;
            if (rq.operation == OP_LOAD) begin
              r.read_data = word_mem[{l, rq.access_address[2:0]}];
            end else begin
              word_mem[{l, rq.access_address[2:0]}] = rq.write_data;
              mesi_mem[l] = ST_M;
              dirty_mem[l] = 1;
            end
          end else begin
            stall_flag = 1;
            miss_waiting = 1;
            pend_addr = rq.access_address;
            pend_store = (rq.operation == OP_STORE);
            if (pend_store) pend_word = rq.write_data;
          end
        end
      end else if (rq.operation == OP_GRANT) begin
        if (flush_active) begin
          off = 3'(8 - flush_left);
          r.drive_valid = 1;
          r.drive_command = CMD_FLUSH;
          r.drive_address = flush_ptr;
          r.drive_data = word_mem[{flush_ptr[8:3], off}];
          flush_left--;
          flush_ptr = flush_ptr + 21'd1;
          if (flush_left == 0) flush_active = 0;
        end else if (miss_waiting) begin
          r.drive_valid = 1;
          r.drive_command = pend_store ? CMD_BUSRDX : CMD_BUSRD;
          r.drive_address = pend_addr;
          miss_waiting = 0;
          fill_receiving = 1;
          fill_base = {pend_addr[20:3], 3'b000};
          fill_count = 0;
          fill_shared = 0;
          fill_mask = '0;
        end
      end else if (rq.bus_command == CMD_FLUSH) begin
        if (fill_receiving && {rq.bus_address[20:3], 3'b000} == fill_base) begin
          word_mem[{rq.bus_address[8:3], rq.bus_address[2:0]}] = rq.bus_data;
          fill_mask[rq.bus_address[2:0]] = 1;
          fill_count++;
          if (fill_count >= 8) begin
            tag_mem[fill_base[8:3]] = fill_base[20:9];
            mesi_mem[fill_base[8:3]] = fill_shared ? ST_S : ST_E;
            dirty_mem[fill_base[8:3]] = 0;
            fill_receiving = 0;
            stall_flag = 0;
            miss_waiting = 0;
            fill_count = 0;
            r.fill_done = 1;
            if (pend_store) begin
              word_mem[{pend_addr[8:3], pend_addr[2:0]}] = pend_word;
              if (tag_mem[pend_addr[8:3]] == pend_addr[20:9]) begin
                mesi_mem[pend_addr[8:3]] = ST_M;
                dirty_mem[pend_addr[8:3]] = 1;
              end
            end
          end
        end
      end else if (rq.bus_command != CMD_NONE) begin
        l = rq.bus_address[8:3];
        if (rq.bus_originator == {1'b0, own_id}) begin
          if (rq.bus_command == CMD_BUSRD) fill_shared = rq.bus_shared;
        end else if (line_match(rq.bus_address)) begin
          r.shared_assert = 1;
          if (rq.bus_command == CMD_BUSRD) begin
            if (mesi_mem[l] >= ST_E) begin
              mesi_mem[l] = ST_S;
              if (dirty_mem[l]) begin
                dirty_mem[l] = 0;
                begin_flush(l);
                r.cancel_memory = 1;
              end
            end
          end else begin
            mesi_mem[l] = ST_I;
            if (dirty_mem[l]) begin
              dirty_mem[l] = 0;
              begin_flush(l);
              r.cancel_memory = 1;
            end
          end
        end
      end
      r.core_stall = stall_flag;
      r.bus_request = flush_active || miss_waiting;
      rsp_queue.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    // Compare one transferred response with the oldest prediction.
    function void check_result(cache_rsp_t got);
      cache_rsp_t e;
      if (rsp_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected response, expected none actual %0h", $time, got);
        return;
      end
      e = rsp_queue.pop_front();
      checked++;
      if (e.hit && e.read_data != 0) load_hits++;
      if (e.fill_done) fills++;
      if (e.drive_command == CMD_FLUSH) flush_words++;
      compare_field("hit", e.hit, got.hit);
      compare_field("read_data", e.read_data, got.read_data);
      compare_field("core_stall", e.core_stall, got.core_stall);
      compare_field("bus_request", e.bus_request, got.bus_request);
      compare_field("drive_valid", e.drive_valid, got.drive_valid);
      compare_field("drive_command", e.drive_command, got.drive_command);
      compare_field("drive_address", e.drive_address, got.drive_address);
      compare_field("drive_data", e.drive_data, got.drive_data);
      compare_field("shared_assert", e.shared_assert, got.shared_assert);
      compare_field("cancel_memory", e.cancel_memory, got.cancel_memory);
      compare_field("fill_done", e.fill_done, got.fill_done);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_wdata;
  msc_in_if #(.AW(21)) in_ch ();
  msc_out_if #(.AW(21)) out_ch ();

  mesi_snooping_cache_controller DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  mesi_scoreboard sb = new();
  bit quiet_mode = 0;
  bit press_req = 0;
  int idle_cycles = 0;
  int sent_items = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Response monitor.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result({out_ch.hit, out_ch.read_data, out_ch.core_stall, out_ch.bus_request,
                       out_ch.drive_valid, out_ch.drive_command, out_ch.drive_address,
                       out_ch.drive_data, out_ch.shared_assert, out_ch.cancel_memory,
                       out_ch.fill_done});
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d responses outstanding", sb.rsp_queue.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Response receiver with random stall bursts and one long hold-off.
  initial begin : receiver
    int hold;
    hold = 0;
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (press_req) begin
        press_req = 0;
        hold = PRESSURE_CYCLES;
        out_ch.ready <= 0;
      end else if (hold > 0) begin
        hold--;
        out_ch.ready <= 0;
      end else if (!quiet_mode && $urandom_range(0, 6) == 0) begin
        hold = $urandom_range(0, 12);
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  function automatic logic [20:0] hot_addr();
    logic [11:0] t;
    logic [5:0] l;
    case ($urandom_range(0, 3))
      0: t = 12'h000;
      1: t = 12'hFFF;
      2: t = 12'h001;
      default: t = 12'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: l = 6'd0;
      1: l = 6'd63;
      2: l = 6'd5;
      default: l = 6'($urandom);
    endcase
    return {t, l, 3'($urandom)};
  endfunction

  function automatic logic [2:0] other_core();
    logic [2:0] o;
    do o = 3'($urandom_range(0, 4)); while (o == {1'b0, sb.own_id});
    return o;
  endfunction

  // Random request shaped by the predicted state so that misses complete their fills.
  function automatic cache_req_t gen_request();
    cache_req_t rq;
    int r;
    logic [2:0] off;
    rq.operation = OP_SNOOP;
    rq.access_address = 21'($urandom);
    rq.write_data = $urandom;
    rq.bus_command = CMD_NONE;
    rq.bus_originator = 3'($urandom_range(0, 7));
    rq.bus_address = 21'($urandom);
    rq.bus_data = $urandom;
    rq.bus_shared = 1'($urandom);
    r = $urandom_range(0, 99);
    if (sb.stall_flag && !sb.fill_receiving) begin
      if (r < 70) rq.operation = OP_GRANT;
      else if (r < 80) begin
        rq.bus_command = $urandom_range(0, 1) ? CMD_BUSRD : CMD_BUSRDX;
        rq.bus_originator = other_core();
        rq.bus_address = hot_addr();
      end else if (r < 90) begin
        rq.operation = $urandom_range(0, 1) ? OP_LOAD : OP_STORE;
        rq.access_address = hot_addr();
      end else rq.bus_command = 2'($urandom);
    end else if (sb.stall_flag) begin
      if (r < 15 && sb.fill_mask == 0) begin
        rq.bus_command = CMD_BUSRD;
        rq.bus_originator = {1'b0, sb.own_id};
        rq.bus_address = sb.pend_addr;
      end else if (r < 75) begin
        rq.bus_command = CMD_FLUSH;
        rq.bus_originator = 3'($urandom_range(0, 4));
        rq.bus_address = sb.fill_base;
      end else if (r < 85) begin
        rq.bus_command = $urandom_range(0, 1) ? CMD_BUSRD : CMD_BUSRDX;
        rq.bus_originator = other_core();
        rq.bus_address = hot_addr();
      end else if (r < 92) rq.operation = OP_GRANT;
      else rq.bus_command = 2'($urandom);
    end else begin
      if (r < 35) begin
        rq.operation = OP_LOAD;
        rq.access_address = hot_addr();
      end else if (r < 60) begin
        rq.operation = OP_STORE;
        rq.access_address = hot_addr();
      end else if (r < 75) begin
        rq.bus_command = $urandom_range(0, 1) ? CMD_BUSRD : CMD_BUSRDX;
        rq.bus_originator = other_core();
        rq.bus_address = hot_addr();
      end else if (r < 82) rq.operation = OP_GRANT;
      else if (r < 88) rq.operation = $urandom_range(0, 1) ? OP_LOAD : OP_STORE;
      else rq.bus_command = 2'($urandom);
    end
    // A fill word never repeats an offset, so every installed line is fully written.
    if (rq.operation == OP_SNOOP && rq.bus_command == CMD_FLUSH && sb.fill_receiving &&
        {rq.bus_address[20:3], 3'b000} == sb.fill_base &&
        sb.fill_mask[rq.bus_address[2:0]]) begin
      do off = 3'($urandom); while (sb.fill_mask[off]);
      rq.bus_address[2:0] = off;
    end
    return rq;
  endfunction

  // Offer one request and wait for its transfer, with an optional idle burst first.
  task automatic send_request(cache_req_t rq);
    int gap;
    if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      in_ch.valid <= 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    {in_ch.operation, in_ch.access_address, in_ch.write_data, in_ch.bus_command,
     in_ch.bus_originator, in_ch.bus_address, in_ch.bus_data, in_ch.bus_shared} <= rq;
    in_ch.valid <= 1;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_transfer(rq);
    sent_items++;
  endtask

  task automatic write_core_id(logic [1:0] v);
    @(negedge clk);
    in_ch.valid <= 0;
    while (sb.rsp_queue.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_core(v);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic cache_req_t mk(logic [1:0] op, logic [20:0] a, logic [31:0] wd,
                                    logic [1:0] cmd, logic [2:0] orig, logic [20:0] ba,
                                    logic [31:0] bd, logic bs);
    return {op, a, wd, cmd, orig, ba, bd, bs};
  endfunction

  // Stimulus sequence.
  initial begin : stimulus
    logic [1:0] phase_ids[4];
    phase_ids = '{2'd0, 2'd2, 2'd1, 2'd3};
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = '0;
    {in_ch.valid, in_ch.operation, in_ch.access_address, in_ch.write_data,
     in_ch.bus_command, in_ch.bus_originator, in_ch.bus_address, in_ch.bus_data,
     in_ch.bus_shared} = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    write_core_id(2'd3);

    // Directed: miss, ignored access while stalled, fill with shared latch, hits,
    // dirty snoop that flushes, empty grant and a no-op bus cycle.
    send_request(mk(OP_LOAD, 21'h000000, '0, CMD_NONE, 0, '0, '0, 0));
    send_request(mk(OP_STORE, 21'h1FFFFF, 32'hFFFFFFFF, CMD_NONE, 0, '0, '0, 0));
    send_request(mk(OP_GRANT, '0, '0, CMD_NONE, 0, '0, '0, 0));
    send_request(mk(OP_SNOOP, '0, '0, CMD_BUSRD, 3'd3, 21'h000000, '0, 1'b0));
    for (int i = 0; i < 8; i++)
      send_request(mk(OP_SNOOP, '0, '0, CMD_FLUSH, 3'd4, 21'(i), 32'hA5A50000 + i, 1));
    send_request(mk(OP_SNOOP, '0, '0, CMD_FLUSH, 3'd4, 21'h1FFFF8, 32'hFFFFFFFF, 0));
    send_request(mk(OP_LOAD, 21'h000007, '0, CMD_NONE, 0, '0, '0, 0));
    send_request(mk(OP_STORE, 21'h000003, 32'hFFFFFFFF, CMD_NONE, 0, '0, '0, 0));
    send_request(mk(OP_SNOOP, '0, '0, CMD_BUSRDX, 3'd0, 21'h000000, '0, 0));
    for (int i = 0; i < 8; i++)
      send_request(mk(OP_GRANT, '0, '0, CMD_NONE, 0, '0, '0, 0));
    send_request(mk(OP_GRANT, '0, '0, CMD_NONE, 0, '0, '0, 0));
    send_request(mk(OP_SNOOP, '0, '0, CMD_NONE, 3'd7, 21'h1FFFFF, 32'hFFFFFFFF, 1));

    // Random phases, one core identifier each.
    for (int p = 0; p < 4; p++) begin
      write_core_id(phase_ids[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == 100) press_req = 1;
        if (p == 3 && i == PHASE_ITEMS - QUIET_ITEMS) quiet_mode = 1;
        send_request(gen_request());
      end
    end
    @(negedge clk);
    in_ch.valid <= 0;
    while (sb.rsp_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d requests over four core identifiers; checked %0d responses.",
             sent_items, sb.checked);
    $display("Covered %0d completed fills, %0d nonzero load hits, %0d flush words driven.",
             sb.fills, sb.load_hits, sb.flush_words);
    if (sb.errors == 0 && sb.rsp_queue.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
